@@ rtl/merge_sorter_core_macros.svh @@
// ----------------------------------------------------------------------------
// merge_sorter_core_macros.svh
// Assertion macros for the merge sorter; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORTER_CORE_MACROS_SVH
`define MERGE_SORTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, held off during reset
`define MS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("merge sorter check failed");

// next-cycle implication, held off during reset
`define MS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("merge sorter check failed");

`else

`define MS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/msort_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msort_pkg
// Shared constants and types of the merge sorter.
// ----------------------------------------------------------------------------
package msort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W     = CNT_W + 2;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
    } out_t;

    // one write port per bank, read addresses shared by both banks
    typedef struct packed {
        logic              we_a;
        logic              we_b;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr0;
        logic [ADDR_W-1:0] raddr1;
    } mem_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] a0;
        logic [DATA_W-1:0] a1;
        logic [DATA_W-1:0] b0;
        logic [DATA_W-1:0] b1;
    } mem_rsp_t;

endpackage

@@ rtl/msort_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msort_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module msort_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
    output logic [WIDTH-1:0]                           rdata0,
    output logic [WIDTH-1:0]                           rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

@@ rtl/msort_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msort_ctrl
// Load, bottom-up merge passes between two banks, and sorted read-out.
// ----------------------------------------------------------------------------
module msort_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  msort_pkg::in_t     item,
    output logic               busy,
    output logic               result_valid,
    output msort_pkg::out_t    result,
    output msort_pkg::mem_req_t req,
    input  msort_pkg::mem_rsp_t rsp
);

    localparam int CW = msort_pkg::CNT_W;
    localparam int SW = msort_pkg::SUM_W;
    localparam int AW = msort_pkg::ADDR_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW:0]   width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_sel_reg, src_sel_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          rd_last_reg, rd_last_next;
    logic          rd_sel_reg, rd_sel_next;
    logic          result_valid_reg;
    msort_pkg::out_t result_reg, result_next;

    logic [SW-1:0] n_w, mid_sum, hi_sum, width2;
    logic [CW-1:0] mid_c, hi_c, k_inc, cnt_load;
    logic [msort_pkg::DATA_W-1:0] head_a, head_b;
    logic          room, take_left;

    assign n_w      = SW'(cnt_reg);
    assign mid_sum  = SW'(lo_reg) + SW'(width_reg);
    assign hi_sum   = SW'(lo_reg) + {width_reg, 1'b0};
    assign width2   = {width_reg, 1'b0};
    assign mid_c    = (mid_sum > n_w) ? cnt_reg : mid_sum[CW-1:0];
    assign hi_c     = (hi_sum > n_w) ? cnt_reg : hi_sum[CW-1:0];
    assign k_inc    = k_reg + CW'(1);
    assign room     = (cnt_reg < msort_pkg::MAX_CNT);
    assign cnt_load = cnt_reg + CW'(room);

    assign head_a = src_sel_reg ? rsp.b0 : rsp.a0;
    assign head_b = src_sel_reg ? rsp.b1 : rsp.a1;

    // stable: left run wins ties
    assign take_left = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || ($signed(head_a) <= $signed(head_b)));

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        src_sel_next = src_sel_reg;
        rd_valid_next = 1'b0;
        rd_last_next = rd_last_reg;
        rd_sel_next  = rd_sel_reg;
        req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (room)
                    begin
                        req.we_a  = 1'b1;
                        req.waddr = cnt_reg[AW-1:0];
                        req.wdata = item.value;
                    end
                    cnt_next = cnt_load;
                    if (item.last_in)
                    begin
                        src_sel_next = 1'b0;
                        width_next   = (CW + 1)'(1);
                        lo_next      = '0;
                        k_next       = '0;
                        state_next   = (cnt_load > CW'(1)) ? S_RUN : S_EMIT;
                    end
                end
            end
            S_RUN:
            begin
                mid_next   = mid_c;
                hi_next    = hi_c;
                i_next     = lo_reg;
                j_next     = mid_c;
                k_next     = lo_reg;
                state_next = S_RD;
            end
            S_RD:
            begin
                req.raddr0 = i_reg[AW-1:0];
                req.raddr1 = j_reg[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                req.we_a  = src_sel_reg;
                req.we_b  = !src_sel_reg;
                req.waddr = k_reg[AW-1:0];
                req.wdata = take_left ? head_a : head_b;
                if (take_left)
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    if (hi_reg == cnt_reg)
                    begin
                        src_sel_next = !src_sel_reg;
                        width_next   = width2[CW:0];
                        lo_next      = '0;
                        if (width2 >= n_w)
                        begin
                            k_next     = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_RUN;
                        end
                    end
                    else
                    begin
                        lo_next    = hi_reg;
                        state_next = S_RUN;
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_EMIT:
            begin
                req.raddr0    = k_reg[AW-1:0];
                rd_valid_next = 1'b1;
                rd_last_next  = (k_inc == cnt_reg);
                rd_sel_next   = src_sel_reg;
                k_next        = k_inc;
                if (k_inc == cnt_reg)
                begin
                    cnt_next     = '0;
                    src_sel_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next.sorted_value = rd_sel_reg ? rsp.b0 : rsp.a0;
        result_next.last_out     = rd_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            width_reg        <= '0;
            lo_reg           <= '0;
            mid_reg          <= '0;
            hi_reg           <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            src_sel_reg      <= 1'b0;
            rd_valid_reg     <= 1'b0;
            rd_last_reg      <= 1'b0;
            rd_sel_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            width_reg        <= width_next;
            lo_reg           <= lo_next;
            mid_reg          <= mid_next;
            hi_reg           <= hi_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            src_sel_reg      <= src_sel_next;
            rd_valid_reg     <= rd_valid_next;
            rd_last_reg      <= rd_last_next;
            rd_sel_reg       <= rd_sel_next;
            result_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/merge_sorter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sorter_core
// Stable ascending sort of up to MAX_ITEMS signed 32-bit values by merging.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a value transfer happens on a clock edge with start high and busy
//   low. Values load one per cycle; busy stays low while loading. A transfer
//   with item.last_in set closes the set; values beyond MAX_ITEMS are dropped,
//   but a dropped last_in still closes the set.
//   Sorting: bottom-up merge passes ping-pong between two RAM banks. Each
//   merged element is read (both run heads, S_RD) and then compared and
//   written (S_CMP), after a setup state (S_RUN) per run, over ceil(log2 n)
//   passes; the registered RAM read sits ahead of each compare.
//   Output: n results, one per cycle, each shown for one cycle with
//   result_valid; result.last_out marks the final one. Each result passes
//   through the registered RAM read and then the result register.
//   Reset clears the count and the sequencer; RAM contents are not cleared.
//   The receiver cannot stall: results are presented exactly once.
// ----------------------------------------------------------------------------
`include "merge_sorter_core_macros.svh"

module merge_sorter_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  msort_pkg::in_t  item,
    output logic            busy,
    output logic            result_valid,
    output msort_pkg::out_t result
);

    msort_pkg::mem_req_t req;
    msort_pkg::mem_rsp_t rsp;

    msort_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .req          (req),
        .rsp          (rsp)
    );

    msort_ram #(
        .DEPTH (msort_pkg::MAX_ITEMS),
        .WIDTH (msort_pkg::DATA_W)
    ) u_ram_a (
        .clk    (clk),
        .we     (req.we_a),
        .waddr  (req.waddr),
        .wdata  (req.wdata),
        .raddr0 (req.raddr0),
        .raddr1 (req.raddr1),
        .rdata0 (rsp.a0),
        .rdata1 (rsp.a1)
    );

    msort_ram #(
        .DEPTH (msort_pkg::MAX_ITEMS),
        .WIDTH (msort_pkg::DATA_W)
    ) u_ram_b (
        .clk    (clk),
        .we     (req.we_b),
        .waddr  (req.waddr),
        .wdata  (req.wdata),
        .raddr0 (req.raddr0),
        .raddr1 (req.raddr1),
        .rdata0 (rsp.b0),
        .rdata1 (rsp.b1)
    );

    `MS_ASSERT_NEXT(a_last_starts_sort, clk, rst_n, start && !busy && item.last_in, busy)
    `MS_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, start && !busy && !item.last_in, !busy)
    `MS_ASSERT_NEXT(a_gap_after_last, clk, rst_n, result_valid && result.last_out, !result_valid)
    `MS_ASSERT_NOW(a_one_bank_write, clk, rst_n, req.we_a, !req.we_b)

endmodule
